// ===== hw/rtl/mtsq_pkg.sv =====
package mtsq_pkg;

	// Default width of the tick fields
	localparam int TIME_BITS_DEF = 31;

	// Fixed field widths
	localparam int INDEX_BITS = 31;
	localparam int CODE_BITS  = 4;
	localparam int CLASS_BITS = 4;
	localparam int PULSE_BITS = 17;

	// Configuration register widths
	localparam int NUM_BITS      = 8;
	localparam int UNIT_BITS     = 7;
	localparam int PPQ_BITS      = 15;
	localparam int CFG_DATA_BITS = 15;
	localparam int CFG_IDX_BITS  = 2;

	// Derived value widths
	localparam int BEAT_BITS = 17;
	localparam int MLEN_BITS = 24;
	localparam int THR_BITS  = 17;

	// Number of class thresholds and of valid duration codes
	localparam int NUM_THR   = 9;
	localparam int NUM_CODES = 10;

	// Register reset values
	localparam logic [NUM_BITS-1:0]  RST_BEATS_PER_BAR      = 8'd4;
	localparam logic [UNIT_BITS-1:0] RST_BEAT_UNIT          = 7'd4;
	localparam logic [PPQ_BITS-1:0]  RST_PULSES_PER_QUARTER = 15'd480;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_BEATS_PER_BAR      = 2'd0,
		REG_BEAT_UNIT          = 2'd1,
		REG_PULSES_PER_QUARTER = 2'd2
	} cfg_reg_t;

	typedef enum logic [CODE_BITS-1:0] {
		DUR_WHOLE          = 4'd0,
		DUR_DOTTED_HALF    = 4'd1,
		DUR_HALF           = 4'd2,
		DUR_DOTTED_QUARTER = 4'd3,
		DUR_QUARTER        = 4'd4,
		DUR_DOTTED_EIGHTH  = 4'd5,
		DUR_EIGHTH         = 4'd6,
		DUR_TRIPLET        = 4'd7,
		DUR_SIXTEENTH      = 4'd8,
		DUR_THIRTY_SECOND  = 4'd9
	} dur_t;

	// Signature-derived values; the user must keep them static while items are in flight, not enforced
	typedef struct packed {
		logic [MLEN_BITS-1:0]                  meas_len;
		logic                                  meas_zero;
		logic [NUM_THR-1:0][THR_BITS-1:0]      thr;
		logic [NUM_CODES-1:0][PULSE_BITS-1:0]  code_len;
	} cfg_drv_t;

	// Result fields that ride alongside the measure division
	typedef struct packed {
		logic [CODE_BITS-1:0]  stem;
		logic [PULSE_BITS-1:0] pulses;
		logic [CLASS_BITS-1:0] nearest;
	} side_t;

endpackage

// ===== hw/rtl/midi_time_signature_quantizer.sv =====
// Pipeline: three front stages, then one divider stage per quotient bit.
// Throughput: one beat per cycle; every stage advances together whenever
// the output register is empty or being taken, and stalls otherwise.
// Reset clears all valid bits and loads 4/4 time at 480 ticks per quarter.
// Derived signature values are registered after a write (meas_len via beat_q).
module midi_time_signature_quantizer import mtsq_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,

	input  logic                     s_tvalid,
	output logic                     s_tready,
	// time_pulses, length_pulses, duration_code
	input  logic [((2*TIME_BITS+CODE_BITS+7)/8)*8-1:0] s_tdata,

	output logic                     m_tvalid,
	input  logic                     m_tready,
	// measure_index, measure_error, nearest_duration, code_pulses, stem_code
	output logic [((INDEX_BITS+1+CLASS_BITS+PULSE_BITS+CODE_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int OUT_W = ((INDEX_BITS + 1 + CLASS_BITS + PULSE_BITS + CODE_BITS + 7) / 8) * 8;

	cfg_drv_t             drv;
	logic                 adv;
	logic                 front_valid;
	logic [TIME_BITS-1:0] front_time;
	side_t                front_side;
	logic                 out_valid;
	logic [TIME_BITS-1:0] out_quot;
	side_t                out_side;
	logic [INDEX_BITS-1:0] meas_index;

	// Advance whenever the output register is free or its beat is taken
	assign adv      = !out_valid || m_tready;
	assign s_tready = adv;

	mtsq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.drv       (drv)
	);

	mtsq_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (s_tvalid),
		.time_pulses   (s_tdata[TIME_BITS-1:0]),
		.length_pulses (s_tdata[2*TIME_BITS-1:TIME_BITS]),
		.duration_code (s_tdata[2*TIME_BITS +: CODE_BITS]),
		.drv           (drv),
		.out_valid     (front_valid),
		.out_time      (front_time),
		.out_side      (front_side)
	);

	mtsq_div #(
		.TIME_BITS (TIME_BITS)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (front_valid),
		.in_dividend (front_time),
		.in_side     (front_side),
		.divisor     (drv.meas_len),
		.out_valid   (out_valid),
		.out_quot    (out_quot),
		.out_side    (out_side)
	);

	// Force the index to zero when the measure length is zero
	assign meas_index = drv.meas_zero ? '0 : INDEX_BITS'(out_quot);

	assign m_tvalid = out_valid;
	assign m_tdata  = OUT_W'({out_side.stem, out_side.pulses, out_side.nearest,
		drv.meas_zero, meas_index});

endmodule

// ===== hw/rtl/mtsq_cfg.sv =====
module mtsq_cfg import mtsq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_drv_t                 drv
);

	localparam int RECIP_BITS  = 21;
	localparam int RECIP_SHIFT = 20;
	localparam int PROD_BITS   = 20;
	localparam int DSEL_BITS   = 5;
	localparam int THIRD_SHIFT = 16;

	localparam logic [UNIT_BITS-1:0] QUARTER_UNIT = 7'd4;
	localparam logic [NUM_BITS-1:0]  FIVE_BEATS   = 8'd5;
	localparam logic [NUM_BITS-1:0]  FOUR_BEATS   = 8'd4;
	localparam logic [PPQ_BITS-1:0]  THIRD_RECIP  = 15'd21846;

	// Threshold multipliers on ppq, then shift (whole/32 -> /8, whole/64 -> /16)
	localparam logic [4:0] THR_MULT [NUM_THR] = '{5'd28, 5'd20, 5'd14, 5'd10, 5'd7,
		5'd5, 5'd6, 5'd5, 5'd3};
	localparam int THR_SHIFT [NUM_THR] = '{3, 3, 3, 3, 3, 3, 4, 4, 4};

	// ceil(2^20 / d): exact floor division of any 15-bit ppq by d
	function automatic logic [RECIP_BITS-1:0] beat_recip(input logic [DSEL_BITS-1:0] d);
		logic [RECIP_BITS-1:0] r;
		unique case (d)
			5'd1:    r = 21'd1048576;
			5'd2:    r = 21'd524288;
			5'd3:    r = 21'd349526;
			5'd4:    r = 21'd262144;
			5'd5:    r = 21'd209716;
			5'd6:    r = 21'd174763;
			5'd7:    r = 21'd149797;
			5'd8:    r = 21'd131072;
			5'd9:    r = 21'd116509;
			5'd10:   r = 21'd104858;
			5'd11:   r = 21'd95326;
			5'd12:   r = 21'd87382;
			5'd13:   r = 21'd80660;
			5'd14:   r = 21'd74899;
			5'd15:   r = 21'd69906;
			5'd16:   r = 21'd65536;
			5'd17:   r = 21'd61681;
			5'd18:   r = 21'd58255;
			5'd19:   r = 21'd55189;
			5'd20:   r = 21'd52429;
			5'd21:   r = 21'd49933;
			5'd22:   r = 21'd47663;
			5'd23:   r = 21'd45591;
			5'd24:   r = 21'd43691;
			5'd25:   r = 21'd41944;
			5'd26:   r = 21'd40330;
			5'd27:   r = 21'd38837;
			5'd28:   r = 21'd37450;
			5'd29:   r = 21'd36158;
			5'd30:   r = 21'd34953;
			5'd31:   r = 21'd33826;
			default: r = '0;
		endcase
		return r;
	endfunction

	logic [NUM_BITS-1:0]  beats_q;
	logic [UNIT_BITS-1:0] unit_q;
	logic [PPQ_BITS-1:0]  ppq_q;

	logic [BEAT_BITS-1:0]                  beat_q;
	logic [MLEN_BITS-1:0]                  meas_len_q;
	logic [NUM_THR-1:0][THR_BITS-1:0]      thr_q;
	logic [NUM_CODES-1:0][PULSE_BITS-1:0]  code_len_q;

	logic [PPQ_BITS+RECIP_BITS-1:0] beat_prod;
	logic [BEAT_BITS-1:0]           beat_d;
	logic [NUM_BITS-1:0]            num_d;
	logic [PULSE_BITS-1:0]          q_x;
	logic [PULSE_BITS-1:0]          e_x;
	logic [PULSE_BITS-1:0]          s_x;
	logic [2*PPQ_BITS-1:0]          third_prod;

	// Write the time signature registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beats_q <= RST_BEATS_PER_BAR;
			unit_q  <= RST_BEAT_UNIT;
			ppq_q   <= RST_PULSES_PER_QUARTER;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BEATS_PER_BAR:      beats_q <= cfg_data[NUM_BITS-1:0];
				REG_BEAT_UNIT:          unit_q  <= cfg_data[UNIT_BITS-1:0];
				REG_PULSES_PER_QUARTER: ppq_q   <= cfg_data[PPQ_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Beat length: 2*ppq below a quarter unit, else ppq / (unit/4)
	always_comb begin
		beat_prod = {{RECIP_BITS{1'b0}}, ppq_q}
			* {{PPQ_BITS{1'b0}}, beat_recip(unit_q[UNIT_BITS-1:2])};
		if (unit_q < QUARTER_UNIT) begin
			beat_d = {1'b0, ppq_q, 1'b0};
		end else begin
			beat_d = BEAT_BITS'(beat_prod >> RECIP_SHIFT);
		end
		num_d = (beats_q == FIVE_BEATS) ? FOUR_BEATS : beats_q;
	end

	// Note lengths from ppq
	always_comb begin
		q_x        = PULSE_BITS'(ppq_q);
		e_x        = q_x >> 1;
		s_x        = q_x >> 2;
		third_prod = {{PPQ_BITS{1'b0}}, ppq_q} * {{PPQ_BITS{1'b0}}, THIRD_RECIP};
	end

	// Register the derived values; meas_len_q is computed from the registered beat_q
	always_ff @(posedge clk) begin
		beat_q     <= beat_d;
		meas_len_q <= MLEN_BITS'({{BEAT_BITS{1'b0}}, num_d} * {{NUM_BITS{1'b0}}, beat_q});
		for (int i = 0; i < NUM_THR; i++) begin
			thr_q[i] <= THR_BITS'((PROD_BITS'(THR_MULT[i]) * PROD_BITS'(ppq_q))
				>> THR_SHIFT[i]);
		end
		code_len_q[DUR_WHOLE]          <= q_x << 2;
		code_len_q[DUR_DOTTED_HALF]    <= q_x + (q_x << 1);
		code_len_q[DUR_HALF]           <= q_x << 1;
		code_len_q[DUR_DOTTED_QUARTER] <= e_x + (e_x << 1);
		code_len_q[DUR_QUARTER]        <= q_x;
		code_len_q[DUR_DOTTED_EIGHTH]  <= s_x + (s_x << 1);
		code_len_q[DUR_EIGHTH]         <= e_x;
		code_len_q[DUR_TRIPLET]        <= PULSE_BITS'(third_prod >> THIRD_SHIFT);
		code_len_q[DUR_SIXTEENTH]      <= s_x;
		code_len_q[DUR_THIRTY_SECOND]  <= s_x >> 1;
	end

	assign drv.meas_len  = meas_len_q;
	assign drv.meas_zero = (meas_len_q == '0);
	assign drv.thr       = thr_q;
	assign drv.code_len  = code_len_q;

endmodule

// ===== hw/rtl/mtsq_front.sv =====
module mtsq_front import mtsq_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic [TIME_BITS-1:0] time_pulses,
	input  logic [TIME_BITS-1:0] length_pulses,
	input  logic [CODE_BITS-1:0] duration_code,
	input  cfg_drv_t             drv,
	output logic                 out_valid,
	output logic [TIME_BITS-1:0] out_time,
	output side_t                out_side
);

	localparam int CMP_BITS = (TIME_BITS > THR_BITS) ? TIME_BITS : THR_BITS;

	logic                 valid_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic [TIME_BITS-1:0] len_s1;
	logic [CODE_BITS-1:0] code_s1;

	logic                 valid_s2;
	logic [TIME_BITS-1:0] time_s2;
	logic [TIME_BITS-1:0] len_s2;
	logic [CODE_BITS-1:0] code_s2;
	logic [CODE_BITS-1:0] stem_s2;

	logic                 valid_s3;
	logic [TIME_BITS-1:0] time_s3;
	side_t                side_s3;

	logic [CODE_BITS-1:0]  stem_d;
	logic [CLASS_BITS-1:0] nearest_d;
	logic [PULSE_BITS-1:0] pulses_d;

	// Valid bits advance with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Map dotted classes to their undotted stem
	always_comb begin
		case (code_s1)
			DUR_DOTTED_HALF:    stem_d = DUR_HALF;
			DUR_DOTTED_QUARTER: stem_d = DUR_QUARTER;
			DUR_DOTTED_EIGHTH:  stem_d = DUR_EIGHTH;
			default:            stem_d = code_s1;
		endcase
	end

	// Take the first threshold that the length reaches; none gives thirty-second
	always_comb begin
		nearest_d = DUR_THIRTY_SECOND;
		for (int i = NUM_THR - 1; i >= 0; i--) begin
			if (CMP_BITS'(len_s2) >= CMP_BITS'(drv.thr[i])) begin
				nearest_d = CLASS_BITS'(i);
			end
		end
		if (code_s2 < CODE_BITS'(NUM_CODES)) begin
			pulses_d = drv.code_len[code_s2];
		end else begin
			pulses_d = '0;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			time_s1 <= time_pulses;
			len_s1  <= length_pulses;
			code_s1 <= duration_code;

			time_s2 <= time_s1;
			len_s2  <= len_s1;
			code_s2 <= code_s1;
			stem_s2 <= stem_d;

			time_s3         <= time_s2;
			side_s3.stem    <= stem_s2;
			side_s3.pulses  <= pulses_d;
			side_s3.nearest <= nearest_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_time  = time_s3;
	assign out_side  = side_s3;

	a_nearest_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> side_s3.nearest <= CLASS_BITS'(DUR_THIRTY_SECOND))
		else $error("nearest class out of range");

	a_stem_undotted: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (side_s3.stem != DUR_DOTTED_HALF) && (side_s3.stem != DUR_DOTTED_QUARTER)
			&& (side_s3.stem != DUR_DOTTED_EIGHTH))
		else $error("stem code still dotted");

	a_invalid_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && (side_s3.stem >= CODE_BITS'(NUM_CODES)) |-> side_s3.pulses == '0)
		else $error("invalid duration code gave nonzero pulses");

endmodule

// ===== hw/rtl/mtsq_div.sv =====
module mtsq_div import mtsq_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic [TIME_BITS-1:0] in_dividend,
	input  side_t                in_side,
	input  logic [MLEN_BITS-1:0] divisor,
	output logic                 out_valid,
	output logic [TIME_BITS-1:0] out_quot,
	output side_t                out_side
);

	// One quotient bit per stage, MSB first; work holds remaining dividend
	// bits on top and finished quotient bits below
	logic [TIME_BITS-1:0] vld_s;
	logic [MLEN_BITS-1:0] rem_s  [TIME_BITS];
	logic [TIME_BITS-1:0] work_s [TIME_BITS];
	side_t                side_s [TIME_BITS];

	logic [MLEN_BITS-1:0] rem_n  [TIME_BITS];
	logic [TIME_BITS-1:0] work_n [TIME_BITS];
	side_t                side_n [TIME_BITS];

	for (genvar g = 0; g < TIME_BITS; g++) begin : g_step
		logic [MLEN_BITS-1:0] prev_rem;
		logic [TIME_BITS-1:0] prev_work;
		logic [MLEN_BITS:0]   trial;
		logic [MLEN_BITS:0]   diff;
		logic                 fits;

		if (g == 0) begin : g_first
			assign prev_rem  = '0;
			assign prev_work = in_dividend;
			assign side_n[g] = in_side;
		end else begin : g_next
			assign prev_rem  = rem_s[g-1];
			assign prev_work = work_s[g-1];
			assign side_n[g] = side_s[g-1];
		end

		// Shift in the next dividend bit, subtract when the divisor fits
		assign trial     = {prev_rem, prev_work[TIME_BITS-1]};
		assign diff      = trial - {1'b0, divisor};
		assign fits      = (trial >= {1'b0, divisor});
		assign rem_n[g]  = fits ? diff[MLEN_BITS-1:0] : trial[MLEN_BITS-1:0];
		assign work_n[g] = {prev_work[TIME_BITS-2:0], fits};
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[TIME_BITS-2:0], in_valid};
		end
	end

	// Advance partial remainders, quotients and side fields
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s  <= rem_n;
			work_s <= work_n;
			side_s <= side_n;
		end
	end

	assign out_valid = vld_s[TIME_BITS-1];
	assign out_quot  = work_s[TIME_BITS-1];
	assign out_side  = side_s[TIME_BITS-1];

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("divider stage valid changed during stall");

	a_last_shift: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> vld_s[TIME_BITS-1] == $past(vld_s[TIME_BITS-2]))
		else $error("divider lost or repeated an item at the last stage");

endmodule

// ===== tb/midi_time_signature_quantizer_tb.sv =====
`timescale 1ns / 100ps

module midi_time_signature_quantizer_tb;
	import mtsq_pkg::*;

	localparam int TB_TIME_BITS = TIME_BITS_DEF;
	localparam int S_BITS = ((2*TB_TIME_BITS+CODE_BITS+7)/8)*8;
	localparam int M_BITS = ((INDEX_BITS+1+CLASS_BITS+PULSE_BITS+CODE_BITS+7)/8)*8;
	localparam longint unsigned TICK_MAX = (64'd1 << TB_TIME_BITS) - 1;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = TB_TIME_BITS + 10;
	localparam int SETTLE_CYCLES = 4;
	localparam int NUM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 85;
	localparam int DIRECTED_ITEMS = 22;

	// Threshold numerators: the first six over 32nds of a whole note, the rest over 64ths
	localparam int unsigned THR_NUMER [NUM_THR] = '{28, 20, 14, 10, 7, 5, 6, 5, 3};

	// Fixed signatures: numerator 5, largest values, short beat, numerator 0,
	// denominator 0, widest denominator, ppq 0, tiny ppq
	localparam logic [NUM_BITS-1:0]  SET_BEATS [8] = '{5, 255, 1, 0, 3, 7, 6, 2};
	localparam logic [UNIT_BITS-1:0] SET_UNIT  [8] = '{8, 2, 64, 4, 0, 127, 16, 1};
	localparam logic [PPQ_BITS-1:0]  SET_PPQ   [8] = '{960, 32767, 1, 480, 100, 32767, 0, 3};

	typedef struct packed {
		logic [CODE_BITS-1:0]    duration_code;
		logic [TB_TIME_BITS-1:0] length_pulses;
		logic [TB_TIME_BITS-1:0] time_pulses;
	} query_t;

	typedef struct packed {
		logic [CODE_BITS-1:0]   stem_code;
		logic [PULSE_BITS-1:0]  code_pulses;
		logic [CLASS_BITS-1:0]  nearest_duration;
		logic                   measure_error;
		logic [INDEX_BITS-1:0]  measure_index;
	} result_t;

	localparam int QUERY_BITS = $bits(query_t);
	localparam int RESULT_BITS = $bits(result_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// time_pulses, length_pulses, duration_code
	logic [S_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// measure_index, measure_error, nearest_duration, code_pulses, stem_code
	logic [M_BITS-1:0] m_tdata;

	// Time signature as the block holds it
	logic [NUM_BITS-1:0]  sig_beats = RST_BEATS_PER_BAR;
	logic [UNIT_BITS-1:0] sig_unit  = RST_BEAT_UNIT;
	logic [PPQ_BITS-1:0]  sig_ppq   = RST_PULSES_PER_QUARTER;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int stall_cycles = 0;

	query_t  pending_queries [$];
	result_t expected_results [$];

	midi_time_signature_quantizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned measure_length();
		longint unsigned num;
		longint unsigned ppq;
		longint unsigned beat;
		num = (sig_beats == 8'd5) ? 64'd4 : 64'(sig_beats);
		ppq = sig_ppq;
		if (sig_unit < 7'd4) begin
			beat = 2 * ppq;
		end else begin
			beat = ppq / 64'(sig_unit / 7'd4);
		end
		return num * beat;
	endfunction

	function automatic longint unsigned class_threshold(int idx);
		longint unsigned whole;
		whole = sig_ppq;
		whole = whole * 4 * THR_NUMER[idx];
		return (idx < 6) ? whole / 32 : whole / 64;
	endfunction

	function automatic longint unsigned code_length(logic [CODE_BITS-1:0] code);
		longint unsigned q;
		longint unsigned e;
		longint unsigned s;
		longint unsigned len;
		q = sig_ppq;
		e = q / 2;
		s = e / 2;
		case (code)
			DUR_WHOLE:          len = 4 * q;
			DUR_DOTTED_HALF:    len = 3 * q;
			DUR_HALF:           len = 2 * q;
			DUR_DOTTED_QUARTER: len = 3 * e;
			DUR_QUARTER:        len = q;
			DUR_DOTTED_EIGHTH:  len = 3 * s;
			DUR_EIGHTH:         len = e;
			DUR_TRIPLET:        len = q / 3;
			DUR_SIXTEENTH:      len = s;
			DUR_THIRTY_SECOND:  len = s / 2;
			default:            len = 0;
		endcase
		return len;
	endfunction

	// Work out the result of one query under the current signature
	function automatic result_t quantize(query_t q);
		result_t r;
		longint unsigned mlen;
		longint unsigned span;
		int cls;
		mlen = measure_length();
		if (mlen == 0) begin
			r.measure_index = '0;
			r.measure_error = 1'b1;
		end else begin
			r.measure_index = INDEX_BITS'(64'(q.time_pulses) / mlen);
			r.measure_error = 1'b0;
		end
		// first threshold reached in order wins; scan backwards so the lowest sticks
		span = q.length_pulses;
		cls = 9;
		for (int i = NUM_THR - 1; i >= 0; i--) begin
			if (span >= class_threshold(i))
				cls = i;
		end
		r.nearest_duration = CLASS_BITS'(cls);
		r.code_pulses = PULSE_BITS'(code_length(q.duration_code));
		case (q.duration_code)
			DUR_DOTTED_HALF:    r.stem_code = DUR_HALF;
			DUR_DOTTED_QUARTER: r.stem_code = DUR_QUARTER;
			DUR_DOTTED_EIGHTH:  r.stem_code = DUR_EIGHTH;
			default:            r.stem_code = q.duration_code;
		endcase
		return r;
	endfunction

	// Bias ticks toward measure edges and lengths toward class thresholds
	function automatic query_t random_query();
		query_t q;
		longint unsigned mlen;
		longint unsigned v;
		mlen = measure_length();
		case ($urandom_range(3))
			0: v = $urandom;
			1: begin
				if (mlen != 0)
					v = mlen * $urandom_range(0, 32'(TICK_MAX / mlen)) + $urandom_range(2) - 1;
				else
					v = $urandom;
			end
			2: v = $urandom_range(100000);
			default: v = TICK_MAX - $urandom_range(1000);
		endcase
		q.time_pulses = TB_TIME_BITS'(v);
		case ($urandom_range(2))
			0: v = $urandom;
			1: v = class_threshold($urandom_range(NUM_THR - 1)) + $urandom_range(2) - 1;
			default: v = $urandom_range(8 * 32'(sig_ppq) + 8);
		endcase
		q.length_pulses = TB_TIME_BITS'(v);
		q.duration_code = CODE_BITS'(($urandom_range(3) == 0) ? $urandom_range(15)
			: $urandom_range(9));
		return q;
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_BEATS_PER_BAR:      sig_beats = value[NUM_BITS-1:0];
			REG_BEAT_UNIT:          sig_unit = value[UNIT_BITS-1:0];
			REG_PULSES_PER_QUARTER: sig_ppq = value[PPQ_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_signature(logic [NUM_BITS-1:0] beats, logic [UNIT_BITS-1:0] unit,
			logic [PPQ_BITS-1:0] ppq);
		write_reg(REG_BEATS_PER_BAR, CFG_DATA_BITS'(beats));
		write_reg(REG_BEAT_UNIT, CFG_DATA_BITS'(unit));
		write_reg(REG_PULSES_PER_QUARTER, CFG_DATA_BITS'(ppq));
		// let the derived signature values settle
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Sample between edges so the driver and monitor have finished their updates
	task automatic wait_drained();
		@(negedge clk);
		while (pending_queries.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_idle(int phase);
		case (phase * 3 / NUM_PHASES)
			0: begin
				send_idle_pct = 33;
				recv_idle_pct = 79;
			end
			1: begin
				send_idle_pct = 79;
				recv_idle_pct = 33;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Driver: present the next query when the slot is free, record predictions on accept
	always @(posedge clk or negedge arst_n) begin : driver
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(quantize(query_t'(s_tdata[QUERY_BITS-1:0])));
			if (!s_tvalid || s_tready) begin
				if (pending_queries.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tdata <= S_BITS'(pending_queries.pop_front());
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random and check each result beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : monitor
		result_t got;
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[RESULT_BITS-1:0]);
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: %h", m_tdata);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (got.measure_index !== want.measure_index) begin
						$error("measure_index: expected %0d, got %0d",
							want.measure_index, got.measure_index);
						mismatches++;
					end
					if (got.measure_error !== want.measure_error) begin
						$error("measure_error: expected %0d, got %0d",
							want.measure_error, got.measure_error);
						mismatches++;
					end
					if (got.nearest_duration !== want.nearest_duration) begin
						$error("nearest_duration: expected %0d, got %0d",
							want.nearest_duration, got.nearest_duration);
						mismatches++;
					end
					if (got.code_pulses !== want.code_pulses) begin
						$error("code_pulses: expected %0d, got %0d",
							want.code_pulses, got.code_pulses);
						mismatches++;
					end
					if (got.stem_code !== want.stem_code) begin
						$error("stem_code: expected %0d, got %0d",
							want.stem_code, got.stem_code);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("midi_time_signature_quantizer regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : stimulus
		query_t q;
		longint unsigned mlen;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed queries at the reset signature: extremes, every code,
		// lengths on and just below each class threshold
		set_idle(0);
		mlen = measure_length();
		for (int n = 0; n < DIRECTED_ITEMS; n++) begin
			case (n % 4)
				0: q.time_pulses = '0;
				1: q.time_pulses = TB_TIME_BITS'(TICK_MAX);
				2: q.time_pulses = TB_TIME_BITS'(mlen - 1);
				default: q.time_pulses = TB_TIME_BITS'(mlen);
			endcase
			if (n < 2 * NUM_THR)
				q.length_pulses = TB_TIME_BITS'(class_threshold(n / 2) - (n % 2));
			else
				q.length_pulses = (n % 2) ? TB_TIME_BITS'(TICK_MAX) : '0;
			q.duration_code = CODE_BITS'(n % 16);
			pending_queries.push_back(q);
		end

		// Random queries, one phase per signature
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0) begin
				wait_drained();
				if (phase <= 8)
					program_signature(SET_BEATS[phase-1], SET_UNIT[phase-1], SET_PPQ[phase-1]);
				else
					program_signature(NUM_BITS'($urandom_range(255)),
						UNIT_BITS'($urandom_range(127)), PPQ_BITS'($urandom_range(32767)));
				set_idle(phase);
			end
			repeat (ITEMS_PER_PHASE) pending_queries.push_back(random_query());
		end

		// Drain, then allow the pipeline depth for stray beats
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("midi_time_signature_quantizer regression: pass");
		end else begin
			$display("midi_time_signature_quantizer regression: fail");
		end
		$finish;
	end

endmodule
